### rtl/lrlm_pkg.sv
// Shared types and display constants for the LED matrix line rasterizer.
// No dependencies; used by lrlm_ctrl, lrlm_dp and line_rasterizer_led_matrix.
package lrlm_pkg;

	localparam int DISPLAY_WIDTH  = 16;
	localparam int DISPLAY_HEIGHT = 16;
	localparam int COORD_BITS     = 6;

	localparam int ROW_W   = 4;
	localparam int COL_W   = 5;
	localparam int COLOR_W = 24;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 48;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [COLOR_W-1:0]    color_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
		logic at_end;
	} status_t;

endpackage

### rtl/lrlm_ctrl.sv
// Line walk sequencer: accepts a segment, then paces pixel emission.
// Depends on lrlm_pkg.
module lrlm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lrlm_pkg::status_t  status,
	output lrlm_pkg::cmd_t     cmd
);

	lrlm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrlm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrlm_pkg::ST_IDLE: begin
				if (in_valid) state_d = lrlm_pkg::ST_RUN;
			end
			lrlm_pkg::ST_RUN: begin
				if (status.out_free && status.at_end) state_d = lrlm_pkg::ST_IDLE;
			end
			default: state_d = lrlm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		unique case (state_q)
			lrlm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			lrlm_pkg::ST_RUN: begin
				cmd.emit = status.out_free;
			end
			default: ;
		endcase
	end

endmodule

### rtl/lrlm_dp.sv
// Bresenham datapath: cursor, error term, strip mapping and output register.
// Depends on lrlm_pkg.
module lrlm_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lrlm_pkg::cmd_t            cmd,
	output lrlm_pkg::status_t         status,
	input  lrlm_pkg::coord_t          start_x,
	input  lrlm_pkg::coord_t          start_y,
	input  lrlm_pkg::coord_t          end_x,
	input  lrlm_pkg::coord_t          end_y,
	input  lrlm_pkg::color_t          line_color,
	output logic                      out_valid,
	input  logic                      out_ready,
	output lrlm_pkg::coord_t          pixel_x,
	output lrlm_pkg::coord_t          pixel_y,
	output logic [lrlm_pkg::ROW_W-1:0] strip_row,
	output logic [lrlm_pkg::COL_W-1:0] strip_column,
	output lrlm_pkg::color_t          pixel_color,
	output logic                      visible,
	output logic                      last
);

	localparam int CW = lrlm_pkg::COORD_BITS;
	localparam int DW = CW + 1;   // signed difference / doubled magnitude
	localparam int EW = CW + 3;   // error term

	lrlm_pkg::coord_t cursor_x_q, cursor_y_q, target_x_q, target_y_q;
	logic [EW-1:0]    error_term_q;
	logic [DW-1:0]    twice_dx_q, twice_dy_q;
	logic             x_step_negative_q, y_step_negative_q, x_major_q;
	lrlm_pkg::color_t held_color_q;
	logic             out_valid_q;

	// segment setup
	logic [DW-1:0] dx_raw, dy_raw, dx_abs, dy_abs, twice_dx, twice_dy;
	logic          x_maj;
	logic [EW-1:0] err_init;

	always_comb begin
		dx_raw   = {1'b0, end_x} - {1'b0, start_x};
		dy_raw   = {1'b0, end_y} - {1'b0, start_y};
		dx_abs   = dx_raw[DW-1] ? (~dx_raw + DW'(1)) : dx_raw;
		dy_abs   = dy_raw[DW-1] ? (~dy_raw + DW'(1)) : dy_raw;
		twice_dx = {dx_abs[CW-1:0], 1'b0};
		twice_dy = {dy_abs[CW-1:0], 1'b0};
		x_maj    = twice_dx > twice_dy;
		err_init = x_maj ? (EW'(twice_dy) - EW'(dx_abs)) : (EW'(twice_dx) - EW'(dy_abs));
	end

	// one step along the line
	logic             at_end, minor_step;
	logic [EW-1:0]    err_next;
	lrlm_pkg::coord_t next_x, next_y;

	always_comb begin
		at_end     = x_major_q ? (cursor_x_q == target_x_q) : (cursor_y_q == target_y_q);
		minor_step = !error_term_q[EW-1];
		if (x_major_q) begin
			err_next = error_term_q + EW'(twice_dy_q) - (minor_step ? EW'(twice_dx_q) : '0);
		end else begin
			err_next = error_term_q + EW'(twice_dx_q) - (minor_step ? EW'(twice_dy_q) : '0);
		end
		next_x = cursor_x_q;
		next_y = cursor_y_q;
		if (x_major_q || minor_step) begin
			next_x = x_step_negative_q ? cursor_x_q - CW'(1) : cursor_x_q + CW'(1);
		end
		if (!x_major_q || minor_step) begin
			next_y = y_step_negative_q ? cursor_y_q - CW'(1) : cursor_y_q + CW'(1);
		end
	end

	// mirror and strip mapping of the current pixel
	logic                        vis;
	logic [DW-1:0]               mx, my, col_full;
	logic [lrlm_pkg::ROW_W-1:0]  row_map;
	logic [lrlm_pkg::COL_W-1:0]  col_map;

	always_comb begin
		vis = ({1'b0, cursor_x_q} < DW'(lrlm_pkg::DISPLAY_WIDTH)) &&
		      ({1'b0, cursor_y_q} < DW'(lrlm_pkg::DISPLAY_HEIGHT));
		mx       = DW'(lrlm_pkg::DISPLAY_WIDTH - 1) - {1'b0, cursor_x_q};
		my       = DW'(lrlm_pkg::DISPLAY_HEIGHT - 1) - {1'b0, cursor_y_q};
		col_full = (mx[0] ? DW'(lrlm_pkg::DISPLAY_HEIGHT) : '0) + my;
		row_map  = vis ? mx[lrlm_pkg::ROW_W:1] : '0;
		col_map  = vis ? col_full[lrlm_pkg::COL_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q        <= '0;
			cursor_y_q        <= '0;
			target_x_q        <= '0;
			target_y_q        <= '0;
			held_color_q      <= '0;
			twice_dx_q        <= '0;
			twice_dy_q        <= '0;
			x_step_negative_q <= 1'b0;
			y_step_negative_q <= 1'b0;
			x_major_q         <= 1'b0;
			error_term_q      <= '0;
		end else if (cmd.load) begin
			cursor_x_q        <= start_x;
			cursor_y_q        <= start_y;
			target_x_q        <= end_x;
			target_y_q        <= end_y;
			held_color_q      <= line_color;
			twice_dx_q        <= twice_dx;
			twice_dy_q        <= twice_dy;
			x_step_negative_q <= dx_raw[DW-1];
			y_step_negative_q <= dy_raw[DW-1];
			x_major_q         <= x_maj;
			error_term_q      <= err_init;
		end else if (cmd.emit && !at_end) begin
			cursor_x_q   <= next_x;
			cursor_y_q   <= next_y;
			error_term_q <= err_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_x      <= '0;
			pixel_y      <= '0;
			strip_row    <= '0;
			strip_column <= '0;
			pixel_color  <= '0;
			visible      <= 1'b0;
			last         <= 1'b0;
		end else if (cmd.emit) begin
			pixel_x      <= cursor_x_q;
			pixel_y      <= cursor_y_q;
			strip_row    <= row_map;
			strip_column <= col_map;
			pixel_color  <= held_color_q;
			visible      <= vis;
			last         <= at_end;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || out_ready;
	assign status.at_end   = at_end;

endmodule

### rtl/line_rasterizer_led_matrix.sv
// Top level of the LED matrix line rasterizer.
// Depends on lrlm_pkg, lrlm_ctrl and lrlm_dp.
//
// Usage:
//  - s_* takes one line segment per item: two end points and a colour.
//  - m_* returns one item per pixel of the segment, first end point first,
//    stepping with the integer Bresenham error rule (x-major when 2|dx|>2|dy|).
//  - Each pixel carries its logical x/y, its strip row and strip column
//    after mirroring on both axes, and the line colour. m_tuser flags pixels
//    on the display; off-display pixels still come out with row/column 0.
//  - m_tlast marks the final pixel (the second end point).
// Timing:
//  - A segment is loaded into the walk registers, the sequencer enters its
//    run state, then one pixel per cycle is registered unless m_tready
//    stalls: a line has N pixels (N = max(|dx|,|dy|)+1, up to 64). The pixel
//    step loop (cursor plus error term update) sets the rate of one pixel per cycle.
//  - s_tready is high while no segment is being walked; it rises again in the
//    cycle after the last pixel enters the output register, even if that
//    pixel is still waiting on m_tready.
//  - A stall on m_tready freezes the walk; the output register holds its item.
// Reset: arst_n clears the sequencer, the walk registers and the output
// register; no pixel is pending afterwards.
module line_rasterizer_led_matrix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], line_color[47:24]
	input  logic [lrlm_pkg::IN_W-1:0]  s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pixel_x[5:0], pixel_y[11:6], strip_row[15:12], strip_column[20:16],
	// pixel_color[44:21], zero[47:45]
	output logic [lrlm_pkg::OUT_W-1:0] m_tdata,
	// visible[0]
	output logic        m_tuser,
	output logic        m_tlast
);

	lrlm_pkg::cmd_t    cmd;
	lrlm_pkg::status_t status;

	lrlm_pkg::coord_t                 pixel_x, pixel_y;
	logic [lrlm_pkg::ROW_W-1:0]       strip_row;
	logic [lrlm_pkg::COL_W-1:0]       strip_column;
	lrlm_pkg::color_t                 pixel_color;

	lrlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lrlm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.start_x      (s_tdata[5:0]),
		.start_y      (s_tdata[11:6]),
		.end_x        (s_tdata[17:12]),
		.end_y        (s_tdata[23:18]),
		.line_color   (s_tdata[47:24]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.strip_row    (strip_row),
		.strip_column (strip_column),
		.pixel_color  (pixel_color),
		.visible      (m_tuser),
		.last         (m_tlast)
	);

	assign m_tdata = {3'b000, pixel_color, strip_column, strip_row, pixel_y, pixel_x};

endmodule
